// ----- rtl/core/stk_pkg.sv -----
package stk_pkg;

  localparam int TOKEN_BUFFER = 256;
  localparam int LenW = $clog2(TOKEN_BUFFER);

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;

  localparam logic [7:0] MaxLenReset = 8'd255;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       last_of_token;
    logic       empty_token;
    logic       was_quoted;
    logic       overflow;
    logic       end_of_input;
  } stk_result_t;

endpackage

// ----- rtl/core/script_tokenizer.sv -----
// Results of an accepted byte are registered in the result queue before they reach the output.
// Throughput: one input byte per cycle while results drain at least as fast as they
//   appear; a byte may give up to two results, held in a four-entry result queue.
// The input stalls when the queue has room for fewer than two results.
// Reset (synchronous, active low): idle scan mode, empty queue, limit register = 255.
module script_tokenizer
  import stk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_token_byte,
  output logic        out_last_of_token,
  output logic        out_empty_token,
  output logic        out_was_quoted,
  output logic        out_overflow,
  output logic        out_end_of_input,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic RegMaxLen = 1'b0;

  logic [7:0]  max_len_r;
  logic        cfg_wr;
  logic        accept;
  logic        room2;
  stk_result_t res0, res1, head;
  logic [1:0]  res_cnt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == RegMaxLen) ? {24'd0, max_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MaxLenReset;
    end else if (cfg_wr && cfg_paddr[2] == RegMaxLen) begin
      max_len_r <= cfg_pwdata[7:0];
    end
  end

  assign in_stall = !room2;
  assign accept   = in_valid && room2;

  stk_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (accept),
    .item_byte  (in_byte),
    .max_len    (max_len_r),
    .res0       (res0),
    .res1       (res1),
    .res_cnt    (res_cnt)
  );

  stk_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (res0),
    .push1      (res1),
    .push_cnt   (res_cnt),
    .room2      (room2),
    .pop        (!out_stall),
    .head_valid (out_valid),
    .head       (head)
  );

  assign out_token_byte    = head.token_byte;
  assign out_last_of_token = head.last_of_token;
  assign out_empty_token   = head.empty_token;
  assign out_was_quoted    = head.was_quoted;
  assign out_overflow      = head.overflow;
  assign out_end_of_input  = head.end_of_input;

endmodule

// ----- rtl/core/stk_scan.sv -----
module stk_scan
  import stk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  logic [7:0]  item_byte,
  input  logic [7:0]  max_len,
  output stk_result_t res0,
  output stk_result_t res1,
  output logic [1:0]  res_cnt
);

  typedef enum logic [2:0] {
    M_IDLE      = 3'd0,
    M_WORD      = 3'd1,
    M_SLASH     = 3'd2,
    M_COMMENT   = 3'd3,
    M_QUOTE     = 3'd4,
    M_QUOTE_BS  = 3'd5,
    M_QUOTE_BSX = 3'd6
  } mode_t;

  localparam logic [16:0] CapExt = 17'(TOKEN_BUFFER - 1);

  mode_t          mode_r, mode_nxt;
  logic [7:0]     hb_r, hb_nxt;
  logic           hv_r, hv_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic           ovf_r, ovf_nxt;

  logic [7:0]  lim8;
  logic [16:0] lim_ext;
  logic [16:0] limit;
  logic        kept;
  logic        is_zero, is_space, is_single;
  logic        app, fin, sgl, eoi, clr, quoted;
  stk_result_t r0, r1;
  logic [1:0]  cnt;

  assign lim8    = (max_len == 8'd0) ? 8'd1 : max_len;
  assign lim_ext = {9'd0, lim8};
  assign limit   = (lim_ext > CapExt) ? CapExt : lim_ext;
  assign kept    = 17'(len_r) < limit;

  assign is_zero   = (item_byte == 8'd0);
  assign is_space  = (item_byte <= CH_SPACE);
  assign is_single = (item_byte == CH_LBRACE) || (item_byte == CH_RBRACE) ||
                     (item_byte == CH_LPAREN) || (item_byte == CH_RPAREN) ||
                     (item_byte == CH_APOS)   || (item_byte == CH_COMMA);

  always_comb begin
    mode_nxt = mode_r;
    hb_nxt   = hb_r;
    hv_nxt   = hv_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    app      = 1'b0;
    fin      = 1'b0;
    sgl      = 1'b0;
    eoi      = 1'b0;
    clr      = 1'b0;
    quoted   = 1'b0;
    r0       = '0;
    r1       = '0;
    cnt      = 2'd0;

    unique case (mode_r)
      M_IDLE: begin
        if (is_zero) begin
          eoi = 1'b1;
        end else if (is_space) begin
          mode_nxt = M_IDLE;
        end else if (item_byte == CH_QUOTE) begin
          clr      = 1'b1;
          mode_nxt = M_QUOTE;
        end else if (is_single) begin
          sgl = 1'b1;
        end else begin
          app      = 1'b1;
          mode_nxt = (item_byte == CH_SLASH) ? M_SLASH : M_WORD;
        end
      end
      M_WORD, M_SLASH: begin
        if (mode_r == M_SLASH && item_byte == CH_SLASH) begin
          clr      = 1'b1;
          mode_nxt = M_COMMENT;
        end else if (is_zero) begin
          fin      = 1'b1;
          eoi      = 1'b1;
          mode_nxt = M_IDLE;
        end else if (is_space) begin
          fin      = 1'b1;
          mode_nxt = M_IDLE;
        end else if (is_single) begin
          fin      = 1'b1;
          sgl      = 1'b1;
          mode_nxt = M_IDLE;
        end else begin
          app      = 1'b1;
          mode_nxt = M_WORD;
        end
      end
      M_COMMENT: begin
        if (is_zero) begin
          eoi      = 1'b1;
          mode_nxt = M_IDLE;
        end else if (item_byte == CH_NEWLINE) begin
          mode_nxt = M_IDLE;
        end
      end
      M_QUOTE, M_QUOTE_BS, M_QUOTE_BSX: begin
        quoted = 1'b1;
        if (mode_r == M_QUOTE_BS && item_byte == CH_QUOTE) begin
          // escaped quote replaces the held backslash
          hb_nxt   = CH_QUOTE;
          mode_nxt = M_QUOTE;
        end else if (mode_r == M_QUOTE_BSX && item_byte == CH_QUOTE) begin
          // backslash was dropped, so the quote goes too
          ovf_nxt  = 1'b1;
          mode_nxt = M_QUOTE;
        end else if (is_zero) begin
          fin      = 1'b1;
          eoi      = 1'b1;
          mode_nxt = M_IDLE;
        end else if (item_byte == CH_QUOTE) begin
          fin      = 1'b1;
          mode_nxt = M_IDLE;
        end else if (item_byte == CH_BSLASH) begin
          app      = 1'b1;
          mode_nxt = kept ? M_QUOTE_BS : M_QUOTE_BSX;
        end else begin
          app      = 1'b1;
          mode_nxt = M_QUOTE;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase

    if (clr) begin
      hb_nxt  = 8'd0;
      hv_nxt  = 1'b0;
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end

    if (app) begin
      if (kept) begin
        if (hv_r) begin
          r0  = '{token_byte: hb_r, last_of_token: 1'b0, empty_token: 1'b0,
                  was_quoted: quoted, overflow: 1'b0, end_of_input: 1'b0};
          cnt = 2'd1;
        end
        hb_nxt  = item_byte;
        hv_nxt  = 1'b1;
        len_nxt = len_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (fin) begin
      r0 = '{token_byte: hv_r ? hb_r : 8'd0, last_of_token: 1'b1, empty_token: !hv_r,
             was_quoted: quoted, overflow: ovf_r, end_of_input: 1'b0};
      cnt     = 2'd1;
      hb_nxt  = 8'd0;
      hv_nxt  = 1'b0;
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end

    if (sgl || eoi) begin
      if (fin) begin
        r1  = '{token_byte: sgl ? item_byte : 8'd0, last_of_token: sgl, empty_token: 1'b0,
                was_quoted: 1'b0, overflow: 1'b0, end_of_input: eoi};
        cnt = 2'd2;
      end else begin
        r0  = '{token_byte: sgl ? item_byte : 8'd0, last_of_token: sgl, empty_token: 1'b0,
                was_quoted: 1'b0, overflow: 1'b0, end_of_input: eoi};
        cnt = 2'd1;
      end
    end
  end

  assign res0    = r0;
  assign res1    = r1;
  assign res_cnt = item_valid ? cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      hv_r   <= 1'b0;
      len_r  <= '0;
      ovf_r  <= 1'b0;
      hb_r   <= 8'd0;
    end else if (item_valid) begin
      mode_r <= mode_nxt;
      hv_r   <= hv_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      hb_r   <= hb_nxt;
    end
  end

  a_held_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r |-> (len_r != '0))
    else $error("held byte with zero token length");

  a_eoi_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt != 2'd0 && res0.end_of_input) |->
      (res0.token_byte == 8'd0 && !res0.last_of_token && !res0.overflow && res_cnt == 2'd1))
    else $error("end-of-input result carries token data");

  a_pair_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt == 2'd2) |-> (res0.last_of_token && (res1.last_of_token || res1.end_of_input)))
    else $error("two results without a finished token first");

endmodule

// ----- rtl/core/stk_resq.sv -----
module stk_resq
  import stk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stk_result_t push0,
  input  stk_result_t push1,
  input  logic [1:0]  push_cnt,
  output logic        room2,
  input  logic        pop,
  output logic        head_valid,
  output stk_result_t head
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  stk_result_t       mem [Depth];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [PtrW:0]     count_r, count_nxt;
  logic [PtrW-1:0]   wp_inc;
  logic              do_pop;

  assign wp_inc     = wp_r + 1'b1;
  assign head_valid = (count_r != '0);
  assign head       = mem[rp_r];
  assign do_pop     = pop && head_valid;
  assign room2      = (count_r <= (PtrW+1)'(Depth - 2));
  assign count_nxt  = count_r + (PtrW+1)'(push_cnt) - (PtrW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wp_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wp_inc] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + PtrW'(push_cnt);
      rp_r    <= rp_r + PtrW'(do_pop);
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PtrW+1)'(Depth))
    else $error("result queue count above depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> ((PtrW+1)'(push_cnt) + count_r <= (PtrW+1)'(Depth)))
    else $error("result queue overrun");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (PtrW'(wp_r - rp_r) == count_r[PtrW-1:0]))
    else $error("queue pointers disagree with count");

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import stk_pkg::*;

  localparam logic [7:0] CH_END      = 8'h00;
  localparam logic [2:0] REG_MAX_LEN = 3'd0;
  localparam int         IDLE_LIMIT  = 1000;
  localparam logic [7:0] SINGLES [6] = '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
                                         CH_APOS, CH_COMMA};

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_WORD, SCAN_SLASH, SCAN_COMMENT,
    SCAN_QUOTE, SCAN_QUOTE_ESC, SCAN_QUOTE_ESC_DROP
  } scan_t;

  // one row of the directed table; n < 0 means the predictor supplies the results
  typedef struct {
    logic [7:0]  b;
    int          cfg;
    int          n;
    stk_result_t r0;
    stk_result_t r1;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_token_byte;
  logic        out_last_of_token;
  logic        out_empty_token;
  logic        out_was_quoted;
  logic        out_overflow;
  logic        out_end_of_input;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  script_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_byte   (out_token_byte),
    .out_last_of_token(out_last_of_token),
    .out_empty_token  (out_empty_token),
    .out_was_quoted   (out_was_quoted),
    .out_overflow     (out_overflow),
    .out_end_of_input (out_end_of_input),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // tokenizer state as predicted
  logic [7:0] lim_reg;
  scan_t      mode;
  logic [7:0] held;
  bit         held_ok;
  int         tok_len;
  bit         tok_ovf;

  stk_result_t new_results[$];
  stk_result_t token_q[$];
  row_t        dir_rows[$];
  stk_result_t blank;

  int bytes_sent;
  int bytes_in;
  int results_out;
  int errors;
  int limits_set;
  int idle_cycles;
  int in_row;
  bit calm;

  function automatic bit is_single(input logic [7:0] b);
    return b == CH_LBRACE || b == CH_RBRACE || b == CH_LPAREN || b == CH_RPAREN ||
           b == CH_APOS || b == CH_COMMA;
  endfunction

  function automatic int cur_limit();
    int lim;
    lim = (lim_reg == 8'd0) ? 1 : int'(lim_reg);
    if (lim > TOKEN_BUFFER - 1) lim = TOKEN_BUFFER - 1;
    return lim;
  endfunction

  function automatic stk_result_t mk(input logic [7:0] b, input bit last, input bit empty,
                                     input bit quoted, input bit ovf, input bit eoi);
    stk_result_t r;
    r.token_byte    = b;
    r.last_of_token = last;
    r.empty_token   = empty;
    r.was_quoted    = quoted;
    r.overflow      = ovf;
    r.end_of_input  = eoi;
    return r;
  endfunction

  task automatic emit(input logic [7:0] b, input bit last, input bit empty,
                      input bit quoted, input bit ovf, input bit eoi);
    new_results.push_back(mk(b, last, empty, quoted, ovf, eoi));
  endtask

  // newest byte is held back so the last one can carry last_of_token
  task automatic keep_byte(input logic [7:0] b, input bit quoted);
    if (tok_len < cur_limit()) begin
      if (held_ok) emit(held, 1'b0, 1'b0, quoted, 1'b0, 1'b0);
      held    = b;
      held_ok = 1'b1;
      tok_len++;
    end else begin
      tok_ovf = 1'b1;
    end
  endtask

  task automatic close_token(input bit quoted);
    if (held_ok) emit(held, 1'b1, 1'b0, quoted, tok_ovf, 1'b0);
    else emit(8'd0, 1'b1, 1'b1, quoted, tok_ovf, 1'b0);
    held_ok = 1'b0;
    held    = 8'd0;
    tok_len = 0;
    tok_ovf = 1'b0;
  endtask

  task automatic word_char(input logic [7:0] b);
    if (b == CH_END) begin
      close_token(1'b0);
      emit(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      mode = SCAN_IDLE;
    end else if (b <= CH_SPACE) begin
      close_token(1'b0);
      mode = SCAN_IDLE;
    end else if (is_single(b)) begin
      close_token(1'b0);
      emit(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      mode = SCAN_IDLE;
    end else begin
      keep_byte(b, 1'b0);
      mode = SCAN_WORD;
    end
  endtask

  task automatic string_char(input logic [7:0] b);
    bit kept;
    if (b == CH_END) begin
      close_token(1'b1);
      emit(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      mode = SCAN_IDLE;
    end else if (b == CH_QUOTE) begin
      close_token(1'b1);
      mode = SCAN_IDLE;
    end else if (b == CH_BSLASH) begin
      kept = tok_len < cur_limit();
      keep_byte(b, 1'b1);
      mode = kept ? SCAN_QUOTE_ESC : SCAN_QUOTE_ESC_DROP;
    end else begin
      keep_byte(b, 1'b1);
      mode = SCAN_QUOTE;
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] b);
    case (mode)
      SCAN_IDLE: begin
        if (b == CH_END) begin
          emit(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        end else if (b > CH_SPACE) begin
          if (b == CH_QUOTE) begin
            held_ok = 1'b0;
            tok_len = 0;
            tok_ovf = 1'b0;
            mode    = SCAN_QUOTE;
          end else if (is_single(b)) begin
            emit(b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
          end else begin
            keep_byte(b, 1'b0);
            mode = (b == CH_SLASH) ? SCAN_SLASH : SCAN_WORD;
          end
        end
      end
      SCAN_WORD: word_char(b);
      SCAN_SLASH: begin
        if (b == CH_SLASH) begin
          held_ok = 1'b0;
          held    = 8'd0;
          tok_len = 0;
          tok_ovf = 1'b0;
          mode    = SCAN_COMMENT;
        end else begin
          word_char(b);
        end
      end
      SCAN_COMMENT: begin
        if (b == CH_END) begin
          emit(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
          mode = SCAN_IDLE;
        end else if (b == CH_NEWLINE) begin
          mode = SCAN_IDLE;
        end
      end
      SCAN_QUOTE_ESC: begin
        // escaped quote replaces the held backslash
        if (b == CH_QUOTE) begin
          held = CH_QUOTE;
          mode = SCAN_QUOTE;
        end else begin
          string_char(b);
        end
      end
      SCAN_QUOTE_ESC_DROP: begin
        if (b == CH_QUOTE) begin
          tok_ovf = 1'b1;
          mode    = SCAN_QUOTE;
        end else begin
          string_char(b);
        end
      end
      SCAN_QUOTE: string_char(b);
      default: mode = SCAN_IDLE;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", results_out, name, got, want));
  endtask

  task automatic add_row(input logic [7:0] b, input int cfg, input int n,
                         input stk_result_t r0, input stk_result_t r1);
    row_t r;
    r.b   = b;
    r.cfg = cfg;
    r.n   = n;
    r.r0  = r0;
    r.r1  = r1;
    dir_rows.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b, input int row);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_byte  = b;
    in_row   = row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // stop feeding, let every expected result arrive, then give the block a few cycles
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (token_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = REG_MAX_LEN;
    cfg_pwdata  = ($urandom() & 32'hFFFF_FF00) | {24'd0, v};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    lim_reg = v;
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[7:0] !== v)
      report_mismatch($sformatf("limit readback %0h want %0h", cfg_prdata[7:0], v));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    limits_set++;
  endtask

  // one piece of script text with random content; mostly well formed
  task automatic feed_piece();
    int kind;
    int len;
    logic [7:0] c;
    kind = $urandom_range(0, 11);
    case (kind)
      0, 1, 2, 3: begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          do c = 8'($urandom_range(33, 255)); while (c == CH_QUOTE || is_single(c));
          send_byte(c, -1);
        end
        if ($urandom_range(0, 2) == 0) send_byte(SINGLES[$urandom_range(0, 5)], -1);
        else send_byte(8'($urandom_range(1, 32)), -1);
      end
      4, 5: send_byte(SINGLES[$urandom_range(0, 5)], -1);
      6, 7: begin
        send_byte(CH_QUOTE, -1);
        len = $urandom_range(0, 5);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0) begin
            send_byte(CH_BSLASH, -1);
            if ($urandom_range(0, 1) == 1) send_byte(CH_QUOTE, -1);
          end else begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            send_byte(c, -1);
          end
        end
        if ($urandom_range(0, 7) == 0) send_byte(CH_END, -1);
        else send_byte(CH_QUOTE, -1);
      end
      8: begin
        send_byte(CH_SLASH, -1);
        send_byte(CH_SLASH, -1);
        len = $urandom_range(0, 4);
        repeat (len) send_byte(8'($urandom_range(32, 126)), -1);
        send_byte(CH_NEWLINE, -1);
      end
      9: begin
        len = $urandom_range(1, 3);
        repeat (len) send_byte(8'($urandom_range(1, 32)), -1);
      end
      10: send_byte(8'($urandom_range(0, 255)), -1);
      default: send_byte(CH_END, -1);
    endcase
  endtask

  // receiver pacing: after each accepted result, stall for a drawn number of cycles
  initial begin : rx_pace
    int w;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        w = calm ? 0 : $urandom_range(0, 7);
        if (w > 0) begin
          @(negedge clk);
          out_stall = 1'b1;
          repeat (w - 1) @(negedge clk);
          @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    stk_result_t got;
    stk_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        new_results.delete();
        tokenize_byte(in_byte);
        if (in_row >= 0 && dir_rows[in_row].n >= 0) begin
          if (dir_rows[in_row].n >= 1) token_q.push_back(dir_rows[in_row].r0);
          if (dir_rows[in_row].n >= 2) token_q.push_back(dir_rows[in_row].r1);
        end else begin
          foreach (new_results[k]) token_q.push_back(new_results[k]);
        end
        bytes_in++;
      end
      if (out_valid && !out_stall) begin
        got = mk(out_token_byte, out_last_of_token, out_empty_token, out_was_quoted,
                 out_overflow, out_end_of_input);
        if (token_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", results_out));
        end else begin
          want = token_q.pop_front();
          check_field("token_byte", got.token_byte, want.token_byte);
          check_field("last_of_token", got.last_of_token, want.last_of_token);
          check_field("empty_token", got.empty_token, want.empty_token);
          check_field("was_quoted", got.was_quoted, want.was_quoted);
          check_field("overflow", got.overflow, want.overflow);
          check_field("end_of_input", got.end_of_input, want.end_of_input);
        end
        results_out++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin : main
    logic [7:0] lims [7];
    int target;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte     = 8'd0;
    in_row      = -1;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = 3'd0;
    cfg_pwdata  = 32'd0;
    calm        = 1'b0;
    blank       = '0;
    bytes_sent  = 0;
    bytes_in    = 0;
    results_out = 0;
    errors      = 0;
    limits_set  = 0;
    idle_cycles = 0;
    lim_reg     = MaxLenReset;
    mode        = SCAN_IDLE;
    held        = 8'd0;
    held_ok     = 1'b0;
    tok_len     = 0;
    tok_ovf     = 1'b0;

    // limit at reset value
    add_row(CH_END, -1, 1, mk(8'd0, 0, 0, 0, 0, 1), blank);
    add_row(CH_SPACE, -1, 0, blank, blank);
    add_row(CH_LBRACE, -1, 1, mk(CH_LBRACE, 1, 0, 0, 0, 0), blank);
    add_row("a", -1, 0, blank, blank);
    add_row("b", -1, -1, blank, blank);
    add_row(CH_RPAREN, -1, 2, mk("b", 1, 0, 0, 0, 0), mk(CH_RPAREN, 1, 0, 0, 0, 0));
    add_row(CH_QUOTE, -1, 0, blank, blank);
    add_row(CH_QUOTE, -1, 1, mk(8'd0, 1, 1, 1, 0, 0), blank);   // empty string
    add_row(CH_SLASH, -1, -1, blank, blank);                    // comment
    add_row(CH_SLASH, -1, -1, blank, blank);
    add_row(8'hff, -1, -1, blank, blank);
    add_row(CH_NEWLINE, -1, -1, blank, blank);
    add_row(CH_SLASH, -1, -1, blank, blank);                    // lone slash word
    add_row("q", -1, -1, blank, blank);
    add_row(8'h01, -1, -1, blank, blank);
    add_row(CH_QUOTE, -1, -1, blank, blank);                    // escapes in a string
    add_row(CH_BSLASH, -1, -1, blank, blank);
    add_row(CH_QUOTE, -1, -1, blank, blank);
    add_row(8'h80, -1, -1, blank, blank);
    add_row(CH_BSLASH, -1, -1, blank, blank);
    add_row("n", -1, -1, blank, blank);
    add_row(CH_END, -1, -1, blank, blank);                      // end inside string
    // zero limit acts as one
    add_row(8'h7f, 0, -1, blank, blank);
    add_row(8'hfe, -1, -1, blank, blank);
    add_row(CH_END, -1, 2, mk(8'h7f, 1, 0, 0, 1, 0), mk(8'd0, 0, 0, 0, 0, 1));
    add_row(CH_QUOTE, -1, -1, blank, blank);
    add_row("x", -1, -1, blank, blank);
    add_row(CH_BSLASH, -1, -1, blank, blank);                   // dropped backslash
    add_row(CH_QUOTE, -1, -1, blank, blank);                    // its quote dropped too
    add_row(CH_QUOTE, -1, 1, mk("x", 1, 0, 1, 1, 0), blank);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0) begin
        drain();
        write_limit(8'(dir_rows[i].cfg));
      end
      send_byte(dir_rows[i].b, i);
    end

    lims = '{8'd2, 8'd255, 8'd1, 8'd0, 8'd4, 8'd3, 8'd0};
    lims[6] = 8'($urandom_range(1, 12));
    for (int p = 0; p < 7; p++) begin
      drain();
      write_limit(lims[p]);
      calm   = ($urandom_range(0, 3) == 0);
      target = bytes_sent + 10;
      while (bytes_sent < target) feed_piece();
    end
    calm = 1'b0;
    drain();
    repeat (6) @(negedge clk);

    $display("fed %0d bytes, checked %0d token results, %0d limit settings",
             bytes_in, results_out, limits_set);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
